[rtl/running_von_neumann_trend_test_macros.svh]
// ============================================================================
// Assertion macros for the running von Neumann trend test
// Short forms of the concurrent assertions used in the RTL of this block.
// ============================================================================
`ifndef RUNNING_VON_NEUMANN_TREND_TEST_MACROS_SVH
`define RUNNING_VON_NEUMANN_TREND_TEST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RVN_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RVN_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rvn_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// rvn_pkg
// Widths, constants, codes and the micro-program of the trend test block.
// ============================================================================
package rvn_pkg;

   // Series limits.
   localparam int SAMPLE_BITS = 24;
   localparam int MAX_POINTS  = 1024;

   // Field and datapath widths.
   localparam int SAMPLE_W   = 24;
   localparam int COUNT_W    = 11;
   localparam int SUM_W      = 34;
   localparam int SQ_W       = 58;
   localparam int CRIT_W     = 16;
   localparam int RATIO_W    = 19;
   localparam int QUO_W      = RATIO_W + 1;
   localparam int ACC_W      = 88;
   localparam int OPA_W      = 34;
   localparam int OPB_W      = 12;
   localparam int PROD_W     = OPA_W + OPB_W;
   localparam int DEN_SHIFT  = QUO_W - 1;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_USED_W = COUNT_W + RATIO_W + 1 + 2;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   // Micro-program layout.
   localparam int STEP_W    = 6;
   localparam int DIV_FIRST = 15;
   localparam int STEP_LAST = DIV_FIRST + QUO_W - 1;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
      SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_POINTS);
   localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

   // Reset values of the critical ratios, unsigned Q0.16.
   localparam logic [CRIT_W-1:0] CRIT_FOUR_RESET  = 16'd51151;
   localparam logic [CRIT_W-1:0] CRIT_FIVE_RESET  = 16'd53766;
   localparam logic [CRIT_W-1:0] CRIT_SIX_RESET   = 16'd58340;
   localparam logic [CRIT_W-1:0] CRIT_SEVEN_RESET = 16'd61335;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CRIT_FOUR  = 2'd0,
      CSR_CRIT_FIVE  = 2'd1,
      CSR_CRIT_SIX   = 2'd2,
      CSR_CRIT_SEVEN = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      VERDICT_NONE     = 2'd0,
      VERDICT_TREND    = 2'd1,
      VERDICT_NO_TREND = 2'd2
   } verdict_type;

   // Multiplier operand A selection.
   typedef enum logic [2:0] {
      A_XM   = 3'd0,
      A_DM   = 3'd1,
      A_Q_LO = 3'd2,
      A_Q_HI = 3'd3,
      A_D_LO = 3'd4,
      A_D_HI = 3'd5,
      A_SUM  = 3'd6
   } a_sel_type;

   // Multiplier operand B digit selection.
   typedef enum logic [2:0] {
      B_XM_LO = 3'd0,
      B_XM_HI = 3'd1,
      B_DM_LO = 3'd2,
      B_DM_HI = 3'd3,
      B_CNT   = 3'd4,
      B_SUM_0 = 3'd5,
      B_SUM_1 = 3'd6,
      B_SUM_2 = 3'd7
   } b_sel_type;

   // Weight of a partial product in the accumulator.
   typedef enum logic [2:0] {
      SH_0  = 3'd0,
      SH_12 = 3'd1,
      SH_16 = 3'd2,
      SH_24 = 3'd3,
      SH_34 = 3'd4,
      SH_50 = 3'd5
   } shift_type;

   typedef enum logic [2:0] {
      ACC_NONE   = 3'd0,
      ACC_LOAD_Q = 3'd1,
      ACC_LOAD_D = 3'd2,
      ACC_CLEAR  = 3'd3,
      ACC_ADD    = 3'd4,
      ACC_SUB    = 3'd5,
      ACC_DIV    = 3'd6
   } acc_op_type;

   typedef enum logic [1:0] {
      STORE_NONE = 2'd0,
      STORE_Q    = 2'd1,
      STORE_D    = 2'd2,
      STORE_DEN  = 2'd3
   } store_type;

   typedef struct packed {
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      shift_type  shift;
      acc_op_type acc_op;
      store_type  store;
   } uop_type;

   localparam uop_type UOP_NOP = '{a_sel: A_XM, b_sel: B_XM_LO, shift: SH_0,
                                   acc_op: ACC_NONE, store: STORE_NONE};

   // Operands prepared when a sample is accepted.
   typedef struct packed {
      logic [SAMPLE_W-1:0] xm;
      logic [SAMPLE_W-1:0] dm;
      logic [SUM_W-1:0]    sum;
      logic [COUNT_W-1:0]  count;
      logic                fresh;
   } operand_type;

   // Sequencer status toward the top level.
   typedef struct packed {
      logic ready;
      logic finish;
   } seq_status_type;

   // One micro-op per step: update Q, update D, form n*Q - S*S,
   // form n*D scaled by 2^16, then restoring division steps.
   function automatic uop_type uop_at(input logic [STEP_W-1:0] step);
      uop_type uop;
      uop = UOP_NOP;
      case (step)
         6'd0: begin
            uop.acc_op = ACC_LOAD_Q;
         end
         6'd1: begin
            uop = '{A_XM, B_XM_LO, SH_0, ACC_ADD, STORE_NONE};
         end
         6'd2: begin
            uop = '{A_XM, B_XM_HI, SH_12, ACC_ADD, STORE_NONE};
         end
         6'd3: begin
            uop.acc_op = ACC_LOAD_D;
            uop.store  = STORE_Q;
         end
         6'd4: begin
            uop = '{A_DM, B_DM_LO, SH_0, ACC_ADD, STORE_NONE};
         end
         6'd5: begin
            uop = '{A_DM, B_DM_HI, SH_12, ACC_ADD, STORE_NONE};
         end
         6'd6: begin
            uop.acc_op = ACC_CLEAR;
            uop.store  = STORE_D;
         end
         6'd7: begin
            uop = '{A_Q_LO, B_CNT, SH_0, ACC_ADD, STORE_NONE};
         end
         6'd8: begin
            uop = '{A_Q_HI, B_CNT, SH_34, ACC_ADD, STORE_NONE};
         end
         6'd9: begin
            uop = '{A_SUM, B_SUM_0, SH_0, ACC_SUB, STORE_NONE};
         end
         6'd10: begin
            uop = '{A_SUM, B_SUM_1, SH_12, ACC_SUB, STORE_NONE};
         end
         6'd11: begin
            uop = '{A_SUM, B_SUM_2, SH_24, ACC_SUB, STORE_NONE};
         end
         6'd12: begin
            uop.acc_op = ACC_CLEAR;
            uop.store  = STORE_DEN;
         end
         6'd13: begin
            uop = '{A_D_LO, B_CNT, SH_16, ACC_ADD, STORE_NONE};
         end
         6'd14: begin
            uop = '{A_D_HI, B_CNT, SH_50, ACC_ADD, STORE_NONE};
         end
         default: begin
            if (step inside {[DIV_FIRST:STEP_LAST]}) begin
               uop.acc_op = ACC_DIV;
            end
         end
      endcase
      return uop;
   endfunction

endpackage

[rtl/rvn_state.sv]
`timescale 1ns / 1ps
// ============================================================================
// rvn_state
// Series bookkeeping: point count, running sum, previous sample, and the
// operands the shared unit squares for the current sample.
// ============================================================================
module rvn_state (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [rvn_pkg::SAMPLE_W-1:0]      sample,
   input  logic                              new_series,
   output rvn_pkg::operand_type              operands
);

   logic [rvn_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [rvn_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [rvn_pkg::SAMPLE_W-1:0] prev_ff, prev_in;
   logic [rvn_pkg::SAMPLE_W-1:0] xm_ff, xm_in;
   logic [rvn_pkg::SAMPLE_W-1:0] dm_ff, dm_in;
   logic                         fresh_ff, fresh_in;

   logic [rvn_pkg::SAMPLE_W-1:0] x;
   logic [rvn_pkg::SAMPLE_W-1:0] diff;
   logic                         fresh;
   logic                         hold;

   // Classify the sample: start of a series, append, or ignored when full.
   always_comb begin
      x     = sample & rvn_pkg::SAMPLE_MASK;
      fresh = new_series || (count_ff == '0);
      hold  = !fresh && (count_ff == rvn_pkg::COUNT_MAX);
      diff  = (prev_ff > x) ? (prev_ff - x) : (x - prev_ff);
   end

   // Next state on an accepted beat. An ignored sample squares to zero.
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      prev_in  = prev_ff;
      xm_in    = xm_ff;
      dm_in    = dm_ff;
      fresh_in = fresh_ff;
      if (accept) begin
         fresh_in = fresh;
         xm_in    = hold ? '0 : x;
         dm_in    = (hold || fresh) ? '0 : diff;
         if (fresh) begin
            count_in = rvn_pkg::COUNT_W'(1);
            sum_in   = rvn_pkg::SUM_W'(x);
            prev_in  = x;
         end else if (!hold) begin
            count_in = count_ff + rvn_pkg::COUNT_W'(1);
            sum_in   = sum_ff + rvn_pkg::SUM_W'(x);
            prev_in  = x;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      prev_ff  <= prev_in;
      xm_ff    <= xm_in;
      dm_ff    <= dm_in;
      fresh_ff <= fresh_in;
   end

   assign operands = '{xm: xm_ff, dm: dm_ff, sum: sum_ff, count: count_ff,
                       fresh: fresh_ff};

endmodule

[rtl/rvn_mac.sv]
`timescale 1ns / 1ps
// ============================================================================
// rvn_mac
// Shared arithmetic unit: a 34x12 multiplier stage followed by one 88-bit
// add/subtract accumulator that also performs restoring division steps.
// ============================================================================
module rvn_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  rvn_pkg::uop_type                  uop,
   input  rvn_pkg::operand_type              operands,
   output logic [rvn_pkg::RATIO_W-1:0]       ratio
);

   logic [rvn_pkg::PROD_W-1:0]  p_ff, p_in;
   rvn_pkg::shift_type          sh_ff;
   rvn_pkg::acc_op_type         op_ff;
   rvn_pkg::store_type          st_ff;
   logic [rvn_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [rvn_pkg::ACC_W-1:0]   dsh_ff, dsh_in;
   logic [rvn_pkg::QUO_W-1:0]   quo_ff, quo_in;
   logic [rvn_pkg::SQ_W-1:0]    sq_ff, sq_in;
   logic [rvn_pkg::SQ_W-1:0]    dsq_ff, dsq_in;

   logic [rvn_pkg::OPA_W-1:0]   opa;
   logic [rvn_pkg::OPB_W-1:0]   opb;
   logic [rvn_pkg::ACC_W-1:0]   p_ext;
   logic [rvn_pkg::ACC_W-1:0]   p_shifted;
   logic [rvn_pkg::ACC_W-1:0]   opnd;
   logic                        use_sub;
   logic [rvn_pkg::ACC_W:0]     res;

   // Stage 1: operand selection and the multiply.
   always_comb begin
      case (uop.a_sel)
         rvn_pkg::A_XM:   opa = rvn_pkg::OPA_W'(operands.xm);
         rvn_pkg::A_DM:   opa = rvn_pkg::OPA_W'(operands.dm);
         rvn_pkg::A_Q_LO: opa = sq_ff[rvn_pkg::OPA_W-1:0];
         rvn_pkg::A_Q_HI: opa = rvn_pkg::OPA_W'(sq_ff[rvn_pkg::SQ_W-1:rvn_pkg::OPA_W]);
         rvn_pkg::A_D_LO: opa = dsq_ff[rvn_pkg::OPA_W-1:0];
         rvn_pkg::A_D_HI: opa = rvn_pkg::OPA_W'(dsq_ff[rvn_pkg::SQ_W-1:rvn_pkg::OPA_W]);
         rvn_pkg::A_SUM:  opa = operands.sum;
         default:         opa = '0;
      endcase
      case (uop.b_sel)
         rvn_pkg::B_XM_LO: opb = operands.xm[11:0];
         rvn_pkg::B_XM_HI: opb = operands.xm[23:12];
         rvn_pkg::B_DM_LO: opb = operands.dm[11:0];
         rvn_pkg::B_DM_HI: opb = operands.dm[23:12];
         rvn_pkg::B_CNT:   opb = rvn_pkg::OPB_W'(operands.count);
         rvn_pkg::B_SUM_0: opb = operands.sum[11:0];
         rvn_pkg::B_SUM_1: opb = operands.sum[23:12];
         rvn_pkg::B_SUM_2: opb = rvn_pkg::OPB_W'(operands.sum[33:24]);
         default:          opb = '0;
      endcase
      p_in = rvn_pkg::PROD_W'(opa) * rvn_pkg::PROD_W'(opb);
   end

   always_ff @(posedge clock) begin
      p_ff  <= p_in;
      sh_ff <= uop.shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= rvn_pkg::ACC_NONE;
         st_ff <= rvn_pkg::STORE_NONE;
      end else begin
         op_ff <= uop.acc_op;
         st_ff <= uop.store;
      end
   end

   // Stage 2: weight the product and run the shared add/subtract.
   always_comb begin
      p_ext = rvn_pkg::ACC_W'(p_ff);
      case (sh_ff)
         rvn_pkg::SH_0:  p_shifted = p_ext;
         rvn_pkg::SH_12: p_shifted = p_ext << 12;
         rvn_pkg::SH_16: p_shifted = p_ext << 16;
         rvn_pkg::SH_24: p_shifted = p_ext << 24;
         rvn_pkg::SH_34: p_shifted = p_ext << 34;
         rvn_pkg::SH_50: p_shifted = p_ext << 50;
         default:        p_shifted = p_ext;
      endcase
      opnd    = (op_ff == rvn_pkg::ACC_DIV) ? dsh_ff : p_shifted;
      use_sub = (op_ff == rvn_pkg::ACC_SUB) || (op_ff == rvn_pkg::ACC_DIV);
      res     = use_sub ? ({1'b0, acc_ff} - {1'b0, opnd})
                        : ({1'b0, acc_ff} + {1'b0, opnd});
   end

   // Accumulator, divisor shift register, quotient and stored square sums.
   always_comb begin
      acc_in = acc_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      sq_in  = sq_ff;
      dsq_in = dsq_ff;
      case (op_ff)
         rvn_pkg::ACC_LOAD_Q: acc_in = operands.fresh ? '0 : rvn_pkg::ACC_W'(sq_ff);
         rvn_pkg::ACC_LOAD_D: acc_in = operands.fresh ? '0 : rvn_pkg::ACC_W'(dsq_ff);
         rvn_pkg::ACC_CLEAR:  acc_in = '0;
         rvn_pkg::ACC_ADD,
         rvn_pkg::ACC_SUB:    acc_in = res[rvn_pkg::ACC_W-1:0];
         rvn_pkg::ACC_DIV: begin
            // A remainder that stays non-negative sets the quotient bit.
            if (!res[rvn_pkg::ACC_W]) begin
               acc_in = res[rvn_pkg::ACC_W-1:0];
            end
            quo_in = {quo_ff[rvn_pkg::QUO_W-2:0], !res[rvn_pkg::ACC_W]};
            dsh_in = dsh_ff >> 1;
         end
         default: acc_in = acc_ff;
      endcase
      case (st_ff)
         rvn_pkg::STORE_Q:   sq_in  = acc_ff[rvn_pkg::SQ_W-1:0];
         rvn_pkg::STORE_D:   dsq_in = acc_ff[rvn_pkg::SQ_W-1:0];
         rvn_pkg::STORE_DEN: dsh_in = acc_ff << rvn_pkg::DEN_SHIFT;
         default:            sq_in  = sq_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      sq_ff  <= sq_in;
      dsq_ff <= dsq_in;
   end

   // A quotient of 2^19 or more, including a zero denominator, saturates.
   assign ratio = quo_ff[rvn_pkg::QUO_W-1] ? rvn_pkg::RATIO_MAX
                                          : quo_ff[rvn_pkg::RATIO_W-1:0];

endmodule

[rtl/rvn_seq.sv]
`timescale 1ns / 1ps
// ============================================================================
// rvn_seq
// Micro-program sequencer that steps the shared unit through one sample.
// ============================================================================
module rvn_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    out_free,
   output rvn_pkg::uop_type        uop,
   output rvn_pkg::seq_status_type status
);

   typedef enum logic [3:0] {
      SEQ_IDLE   = 4'b0001,
      SEQ_RUN    = 4'b0010,
      SEQ_DRAIN  = 4'b0100,
      SEQ_FINISH = 4'b1000
   } seq_state_type;

   seq_state_type                state_ff, state_in;
   logic [rvn_pkg::STEP_W-1:0]   step_ff, step_in;

   // State and step counter.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         SEQ_IDLE: begin
            step_in = '0;
            if (start) begin
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            step_in = step_ff + rvn_pkg::STEP_W'(1);
            if (step_ff == rvn_pkg::STEP_W'(rvn_pkg::STEP_LAST)) begin
               state_in = SEQ_DRAIN;
            end
         end
         SEQ_DRAIN: begin
            state_in = SEQ_FINISH;
         end
         SEQ_FINISH: begin
            if (out_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Issue a micro-op only while running.
   assign uop = (state_ff == SEQ_RUN) ? rvn_pkg::uop_at(step_ff) : rvn_pkg::UOP_NOP;

   assign status.ready  = (state_ff == SEQ_IDLE);
   assign status.finish = (state_ff == SEQ_FINISH) && out_free;

endmodule

[rtl/running_von_neumann_trend_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// running_von_neumann_trend_test
// Running von Neumann ratio of a sample series, with a trend verdict.
// ============================================================================
// Each accepted sample extends (or restarts) a series and yields one result
// beat: the point count, the von Neumann ratio n*D / (n*Q - S*S) as unsigned
// Q3.16 saturated at its maximum, a flag that four or more points were seen,
// and for four to seven points a verdict against the programmed critical
// ratio. After a sample is accepted the block stays busy and takes no new
// sample until it is through with this one. The busy time is a 35-step
// micro-program that drives one shared 34x12 multiplier and one 88-bit
// add/subtract accumulator, 20 steps of which are restoring division steps,
// then a pipeline drain state and a finish state that hands the result to
// the output register. If the output register still holds an untaken beat,
// the finish state repeats until the beat is taken. The result register lets
// the next sample enter while a finished result still waits to be taken.
// ============================================================================
`include "running_von_neumann_trend_test_macros.svh"

module running_von_neumann_trend_test (
   input  logic                                 clock,
   input  logic                                 reset,
   // Sample channel.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rvn_pkg::REQ_DATA_W-1:0]       req_tdata,  // [23:0] sample
   input  logic                                 req_tuser,  // [0] new_series
   // Result channel.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [10:0] point_count, [29:11] ratio, [30] ratio_valid, [32:31] verdict
   output logic [rvn_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // Register write port.
   input  logic                                 csr_wr_en,
   input  logic [rvn_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rvn_pkg::CRIT_W-1:0]           csr_wdata
);

   logic [rvn_pkg::CRIT_W-1:0]   crit_four_ff, crit_four_in;
   logic [rvn_pkg::CRIT_W-1:0]   crit_five_ff, crit_five_in;
   logic [rvn_pkg::CRIT_W-1:0]   crit_six_ff, crit_six_in;
   logic [rvn_pkg::CRIT_W-1:0]   crit_seven_ff, crit_seven_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rvn_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [rvn_pkg::RATIO_W-1:0]  rsp_ratio_ff, rsp_ratio_in;
   logic                         rsp_rvalid_ff, rsp_rvalid_in;
   rvn_pkg::verdict_type         rsp_verdict_ff, rsp_verdict_in;

   logic                         accept;
   logic                         out_free;
   rvn_pkg::operand_type         operands;
   rvn_pkg::uop_type             uop;
   rvn_pkg::seq_status_type      status;
   logic [rvn_pkg::RATIO_W-1:0]  ratio;
   logic [rvn_pkg::CRIT_W-1:0]   crit;
   logic                         in_window;
   rvn_pkg::verdict_type         verdict;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = status.ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   rvn_state u_state (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .sample     (req_tdata[rvn_pkg::SAMPLE_W-1:0]),
      .new_series (req_tuser),
      .operands   (operands)
   );

   rvn_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .out_free (out_free),
      .uop      (uop),
      .status   (status)
   );

   rvn_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .uop      (uop),
      .operands (operands),
      .ratio    (ratio)
   );

   // Critical ratio registers.
   always_comb begin
      crit_four_in  = crit_four_ff;
      crit_five_in  = crit_five_ff;
      crit_six_in   = crit_six_ff;
      crit_seven_in = crit_seven_ff;
      if (csr_wr_en) begin
         case (rvn_pkg::csr_index_type'(csr_index))
            rvn_pkg::CSR_CRIT_FOUR:  crit_four_in  = csr_wdata;
            rvn_pkg::CSR_CRIT_FIVE:  crit_five_in  = csr_wdata;
            rvn_pkg::CSR_CRIT_SIX:   crit_six_in   = csr_wdata;
            rvn_pkg::CSR_CRIT_SEVEN: crit_seven_in = csr_wdata;
            default:                 crit_four_in  = crit_four_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crit_four_ff  <= rvn_pkg::CRIT_FOUR_RESET;
         crit_five_ff  <= rvn_pkg::CRIT_FIVE_RESET;
         crit_six_ff   <= rvn_pkg::CRIT_SIX_RESET;
         crit_seven_ff <= rvn_pkg::CRIT_SEVEN_RESET;
      end else begin
         crit_four_ff  <= crit_four_in;
         crit_five_ff  <= crit_five_in;
         crit_six_ff   <= crit_six_in;
         crit_seven_ff <= crit_seven_in;
      end
   end

   // Verdict: only series of four to seven points are judged.
   always_comb begin
      in_window = 1'b1;
      case (operands.count)
         11'd4:   crit = crit_four_ff;
         11'd5:   crit = crit_five_ff;
         11'd6:   crit = crit_six_ff;
         11'd7:   crit = crit_seven_ff;
         default: begin
            crit      = '0;
            in_window = 1'b0;
         end
      endcase
      if (!in_window) begin
         verdict = rvn_pkg::VERDICT_NONE;
      end else if (ratio <= rvn_pkg::RATIO_W'(crit)) begin
         verdict = rvn_pkg::VERDICT_TREND;
      end else begin
         verdict = rvn_pkg::VERDICT_NO_TREND;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_ratio_in   = rsp_ratio_ff;
      rsp_rvalid_in  = rsp_rvalid_ff;
      rsp_verdict_in = rsp_verdict_ff;
      if (status.finish) begin
         rsp_valid_in   = 1'b1;
         rsp_count_in   = operands.count;
         rsp_ratio_in   = ratio;
         rsp_rvalid_in  = (operands.count >= 11'd4);
         rsp_verdict_in = verdict;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff   <= rsp_count_in;
      rsp_ratio_ff   <= rsp_ratio_in;
      rsp_rvalid_ff  <= rsp_rvalid_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{rvn_pkg::RSP_PAD_W{1'b0}}, rsp_verdict_ff, rsp_rvalid_ff,
                        rsp_ratio_ff, rsp_count_ff};

   // Checks on the sequencing and on the result fields.
   `RVN_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready, "block took a second sample while busy")
   `RVN_ASSERT_IMPLY(a_finish_has_room, clock, reset, status.finish, !rsp_valid_ff || rsp_tready, "result written over an untaken beat")
   `RVN_ASSERT_IMPLY(a_verdict_window, clock, reset, rsp_valid_ff && (rsp_verdict_ff != rvn_pkg::VERDICT_NONE), rsp_rvalid_ff && (rsp_count_ff <= 11'd7), "verdict outside four to seven points")
   `RVN_ASSERT_IMPLY(a_count_range, clock, reset, rsp_valid_ff, (rsp_count_ff != '0) && (rsp_count_ff <= rvn_pkg::COUNT_MAX), "point count out of range")

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb
// Streaming testbench for the running von Neumann trend test block.
// ============================================================================
// Sample beats are driven from a queue of pending samples. Each accepted
// sample also goes through a bit-exact model of the series sums, the ratio
// and the verdict, and its result is queued. Every result beat is compared
// field by field with the oldest queued result. The run starts with a
// directed set of series, then goes through several critical-ratio settings
// with random series of many shapes, and one series long enough to fill up.
// Both sides stall at random except in the last phase.
// ============================================================================

module tb;
   import rvn_pkg::*;

   localparam int     WIDE_W         = 128;
   localparam longint SAMPLE_TOP     = (64'd1 << SAMPLE_W) - 1;
   localparam int     WATCHDOG_LIMIT = 2000;
   localparam int     DRAIN_CYCLES   = 40;

   // One sample beat, new_series above the sample.
   typedef struct packed {
      logic                new_series;
      logic [SAMPLE_W-1:0] sample;
   } sample_beat_t;

   // One result beat, packed as on rsp_tdata, from the highest bit down.
   typedef struct packed {
      verdict_type        verdict;
      logic               ratio_valid;
      logic [RATIO_W-1:0] ratio;
      logic [COUNT_W-1:0] point_count;
   } trend_result_t;

   typedef enum int {
      SHAPE_RAMP,
      SHAPE_NOISY_RAMP,
      SHAPE_FLAT,
      SHAPE_RANDOM,
      SHAPE_RAIL,
      SHAPE_WALK
   } series_shape_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // [23:0] sample
   logic                  req_tuser  = 1'b0;  // [0] new_series
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [10:0] point_count, [29:11] ratio, [30] ratio_valid, [32:31] verdict
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en  = 1'b0;
   csr_index_type         csr_index  = CSR_CRIT_FOUR;
   logic [CRIT_W-1:0]     csr_wdata  = '0;

   // Model state of the series and the programmed critical ratios.
   logic [COUNT_W-1:0]  series_count    = '0;
   logic [SAMPLE_W-1:0] last_sample     = '0;
   logic [SUM_W-1:0]    sample_sum      = '0;
   logic [SQ_W-1:0]     square_sum      = '0;
   logic [SQ_W-1:0]     step_square_sum = '0;
   logic [CRIT_W-1:0]   crit_ratio [4]  = '{CRIT_FOUR_RESET, CRIT_FIVE_RESET,
                                            CRIT_SIX_RESET, CRIT_SEVEN_RESET};

   sample_beat_t  pending_samples [$];
   trend_result_t trend_results_due [$];
   sample_beat_t  offered_sample;
   trend_result_t rsp_beat;
   trend_result_t rsp_due;

   int samples_loaded = 0;
   int results_seen   = 0;
   int failures       = 0;
   int idle_pct       = 0;
   int send_gap       = 0;
   int recv_gap       = 0;
   int quiet_cycles   = 0;

   running_von_neumann_trend_test u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Updates the series with one sample and works out its result.
   function automatic trend_result_t predict_trend(input sample_beat_t beat);
      logic [SAMPLE_W-1:0] x;
      logic [SAMPLE_W-1:0] step;
      logic [WIDE_W-1:0]   n_q;
      logic [WIDE_W-1:0]   s_s;
      logic [WIDE_W-1:0]   den;
      logic [WIDE_W-1:0]   num;
      logic [CRIT_W-1:0]   limit;
      trend_result_t       r;
      x = beat.sample & SAMPLE_MASK;
      if (beat.new_series || series_count == '0) begin
         series_count    = COUNT_W'(1);
         sample_sum      = SUM_W'(x);
         square_sum      = SQ_W'(WIDE_W'(x) * WIDE_W'(x));
         step_square_sum = '0;
         last_sample     = x;
      end else if (series_count < COUNT_MAX) begin
         // A full series ignores further samples until a new one starts.
         step = (last_sample > x) ? last_sample - x : x - last_sample;
         series_count    = series_count + COUNT_W'(1);
         sample_sum      = sample_sum + SUM_W'(x);
         square_sum      = square_sum + SQ_W'(WIDE_W'(x) * WIDE_W'(x));
         step_square_sum = step_square_sum + SQ_W'(WIDE_W'(step) * WIDE_W'(step));
         last_sample     = x;
      end

      // Ratio n*D / (n*Q - S*S) in Q3.16; no deviation or overflow saturates.
      n_q = WIDE_W'(series_count) * WIDE_W'(square_sum);
      s_s = WIDE_W'(sample_sum) * WIDE_W'(sample_sum);
      num = (WIDE_W'(series_count) * WIDE_W'(step_square_sum)) << 16;
      r.ratio = RATIO_MAX;
      if (n_q > s_s) begin
         den = n_q - s_s;
         if (num < (den << RATIO_W)) begin
            r.ratio = RATIO_W'(num / den);
         end
      end

      // Only series of four to seven points get a verdict.
      case (series_count)
         11'd4: limit = crit_ratio[CSR_CRIT_FOUR];
         11'd5: limit = crit_ratio[CSR_CRIT_FIVE];
         11'd6: limit = crit_ratio[CSR_CRIT_SIX];
         default: limit = crit_ratio[CSR_CRIT_SEVEN];
      endcase
      r.verdict = VERDICT_NONE;
      if (series_count >= 4 && series_count <= 7) begin
         r.verdict = (r.ratio <= RATIO_W'(limit)) ? VERDICT_TREND : VERDICT_NO_TREND;
      end
      r.point_count = series_count;
      r.ratio_valid = (series_count >= 4);
      return r;
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   task automatic queue_sample(input logic [SAMPLE_W-1:0] sample, input logic fresh);
      sample_beat_t beat;
      beat.sample     = sample;
      beat.new_series = fresh;
      pending_samples.push_back(beat);
      samples_loaded++;
   endtask

   // Waits until every loaded sample has had its result checked.
   task automatic drain_results();
      while (results_seen != samples_loaded) begin
         @(posedge clock);
      end
   endtask

   // Writes all four critical ratios; only called while the block is idle.
   task automatic program_thresholds(input logic [CRIT_W-1:0] four,
                                     input logic [CRIT_W-1:0] five,
                                     input logic [CRIT_W-1:0] six,
                                     input logic [CRIT_W-1:0] seven);
      csr_index_type     names [4];
      logic [CRIT_W-1:0] values [4];
      names  = '{CSR_CRIT_FOUR, CSR_CRIT_FIVE, CSR_CRIT_SIX, CSR_CRIT_SEVEN};
      values = '{four, five, six, seven};
      for (int i = 0; i < 4; i++) begin
         @(posedge clock);
         csr_wr_en  <= 1'b1;
         csr_index  <= names[i];
         csr_wdata  <= values[i];
         crit_ratio[names[i]] = values[i];
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Loads random series of mixed shapes, with some stray samples between.
   task automatic load_series_mix(input int target);
      int            goal;
      int            len;
      series_shape_t shape;
      longint        base;
      longint        stride;
      longint        amp;
      longint        v;
      logic          rising;
      logic          fresh;
      goal = samples_loaded + target;
      while (samples_loaded < goal) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_sample(SAMPLE_W'($urandom_range(0, SAMPLE_TOP)),
                         1'($urandom_range(0, 1)));
         end else begin
            len    = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 9);
            shape  = series_shape_t'($urandom_range(SHAPE_RAMP, SHAPE_WALK));
            base   = $urandom_range(0, SAMPLE_TOP);
            stride = $urandom_range(1, 1 << $urandom_range(0, 16));
            amp    = stride * $urandom_range(0, 3);
            rising = 1'($urandom_range(0, 1));
            // Now and then a series runs on from the previous one.
            fresh  = ($urandom_range(0, 15) != 0);
            v      = base;
            for (int i = 0; i < len; i++) begin
               case (shape)
                  SHAPE_RAMP: begin
                     v = rising ? base + i * stride : base - i * stride;
                  end
                  SHAPE_NOISY_RAMP: begin
                     v = (rising ? base + i * stride : base - i * stride)
                         + longint'($urandom_range(0, 2 * amp)) - amp;
                  end
                  SHAPE_FLAT: begin
                     v = base;
                  end
                  SHAPE_RANDOM: begin
                     v = $urandom_range(0, SAMPLE_TOP);
                  end
                  SHAPE_RAIL: begin
                     v = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
                  end
                  default: begin
                     v = v + longint'($urandom_range(0, 2 * amp + 2)) - (amp + 1);
                  end
               endcase
               if (v < 0) begin
                  v = 0;
               end else if (v > SAMPLE_TOP) begin
                  v = SAMPLE_TOP;
               end
               queue_sample(SAMPLE_W'(v), (i == 0) ? fresh : 1'b0);
            end
         end
      end
   endtask

   // Sample driver: offers the next pending sample once the last one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            trend_results_due.push_back(predict_trend(offered_sample));
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               offered_sample = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= offered_sample.sample;
               req_tuser  <= offered_sample.new_series;
               if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                  send_gap = $urandom_range(1, 14);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each result beat and stalls the result side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_beat = trend_result_t'(rsp_tdata[RSP_USED_W-1:0]);
            if (trend_results_due.size() == 0) begin
               $error("result beat with no sample outstanding: %h", rsp_tdata);
               failures++;
            end else begin
               rsp_due = trend_results_due.pop_front();
               compare_field("point_count", rsp_due.point_count, rsp_beat.point_count);
               compare_field("ratio", rsp_due.ratio, rsp_beat.ratio);
               compare_field("ratio_valid", rsp_due.ratio_valid, rsp_beat.ratio_valid);
               compare_field("verdict", rsp_due.verdict, rsp_beat.verdict);
               results_seen++;
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_pct > 0 && $urandom_range(0, 399) < idle_pct) begin
               recv_gap = $urandom_range(1, 14);
            end
         end
      end
   end

   // Watchdog: ends the run when no beat or write moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("no beat accepted for %0d cycles", quiet_cycles);
         $display("** running_von_neumann_trend_test: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Phases of stimulus, each under its own critical-ratio setting.
   initial begin
      longint v;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed series at the reset thresholds.
      idle_pct = 30;
      // First sample after reset without a new-series mark, then a flat run:
      // no deviation, so the ratio saturates and no trend is flagged.
      for (int i = 0; i < 4; i++) begin
         queue_sample('0, 1'b0);
      end
      // Rising ramp: trend for four to seven points, no verdict from eight on.
      queue_sample(24'd1, 1'b1);
      for (int i = 2; i <= 8; i++) begin
         queue_sample(SAMPLE_W'(i), 1'b0);
      end
      // Alternating rails: largest swings, high ratio, no trend.
      queue_sample(SAMPLE_W'(SAMPLE_TOP), 1'b1);
      queue_sample('0, 1'b0);
      queue_sample(SAMPLE_W'(SAMPLE_TOP), 1'b0);
      queue_sample('0, 1'b0);
      queue_sample(SAMPLE_W'(SAMPLE_TOP), 1'b0);
      // Two-point series around mid scale.
      queue_sample(24'h800000, 1'b1);
      queue_sample(24'h7FFFFF, 1'b0);
      // Falling ramp from the top.
      queue_sample(24'hFFFFFF, 1'b1);
      queue_sample(24'hFFFFF0, 1'b0);
      queue_sample(24'hFFFFE0, 1'b0);
      queue_sample(24'hFFFFD0, 1'b0);
      drain_results();

      // Highest thresholds: every ratio within Q0.16 range counts as a trend.
      program_thresholds('1, '1, '1, '1);
      idle_pct = 40;
      load_series_mix(300);
      drain_results();

      // Zero thresholds: a trend needs a ratio of exactly zero.
      program_thresholds('0, '0, '0, '0);
      idle_pct = 15;
      load_series_mix(200);
      drain_results();

      // One series that fills up and then ignores samples, near the top of
      // the range to push the sums to their widest.
      program_thresholds(CRIT_W'($urandom), CRIT_W'($urandom), CRIT_W'($urandom),
                         CRIT_W'($urandom));
      idle_pct = 20;
      queue_sample(SAMPLE_W'(SAMPLE_TOP), 1'b1);
      for (int i = 1; i < MAX_POINTS + 6; i++) begin
         v = ($urandom_range(0, 3) != 0) ? SAMPLE_TOP - $urandom_range(0, 3)
                                         : longint'($urandom_range(0, SAMPLE_TOP));
         queue_sample(SAMPLE_W'(v), 1'b0);
      end
      load_series_mix(50);
      drain_results();

      // Thresholds spread around the usual critical values.
      program_thresholds(CRIT_W'($urandom_range(40000, 65535)),
                         CRIT_W'($urandom_range(40000, 65535)),
                         CRIT_W'($urandom_range(40000, 65535)),
                         CRIT_W'($urandom_range(40000, 65535)));
      idle_pct = 35;
      load_series_mix(250);
      drain_results();

      // Back to the reset thresholds, both sides at full rate.
      program_thresholds(CRIT_FOUR_RESET, CRIT_FIVE_RESET, CRIT_SIX_RESET,
                         CRIT_SEVEN_RESET);
      idle_pct = 0;
      load_series_mix(250);
      drain_results();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("** running_von_neumann_trend_test: PASSED **");
      end else begin
         $display("** running_von_neumann_trend_test: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/rvn_pkg.sv
rtl/rvn_state.sv
rtl/rvn_mac.sv
rtl/rvn_seq.sv
rtl/running_von_neumann_trend_test.sv
bench/tb.sv
